>>> hw/rtl/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg - character LCD number writer package
// Opcodes, control word layout and the sequencer's microcode table.
// ----------------------------------------------------------------------------
package clnw_pkg;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CHAR   = 3'd1,
    OP_UDEC   = 3'd2,
    OP_SDEC   = 3'd3,
    OP_HEX    = 3'd4,
    OP_BIN    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_HEX = 2'd1,
    RAD_BIN = 2'd2
  } radix_t;

  typedef enum logic [2:0] {
    SRC_CONST    = 3'd0,
    SRC_ADDR_COL = 3'd1,
    SRC_ADDR_DIG = 3'd2,
    SRC_VALUE    = 3'd3,
    SRC_SIGN     = 3'd4,
    SRC_DIGIT    = 3'd5
  } src_t;

  typedef enum logic [1:0] {
    LAST_NO      = 2'd0,
    LAST_YES     = 2'd1,
    LAST_IF_ZERO = 2'd2,
    LAST_IF_ONE  = 2'd3
  } last_t;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_END  = 2'd1,
    SEQ_BRZ  = 2'd2,
    SEQ_LOOP = 2'd3
  } seq_t;

  typedef logic [3:0] pc_t;

  typedef struct packed {
    logic       emit;
    logic       is_data;
    src_t       src;
    logic [7:0] cbyte;
    last_t      last;
    seq_t       seq;
    pc_t        target;
    logic       col_inc;
    logic       dig_calc;
    logic       dig_adv;
  } uword_t;

  localparam pc_t PC_INIT   = 4'd0;
  localparam pc_t PC_CHAR   = 4'd4;
  localparam pc_t PC_HEX    = 4'd6;
  localparam pc_t PC_SIGNED = 4'd10;
  localparam pc_t PC_NUM    = 4'd12;
  localparam pc_t PC_DIGIT  = 4'd13;

  localparam logic [7:0] CMD_FUNC_SET = 8'h38;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] BASE_LINE0   = 8'h80;
  localparam logic [7:0] BASE_LINE1   = 8'hC0;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_ALPHA_OFS = 8'h37;
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  function automatic uword_t mk(logic emit, logic is_data, src_t src, logic [7:0] cbyte,
                                last_t last, seq_t seq, pc_t target, logic col_inc,
                                logic dig_calc, logic dig_adv);
    uword_t w;
    w.emit     = emit;
    w.is_data  = is_data;
    w.src      = src;
    w.cbyte    = cbyte;
    w.last     = last;
    w.seq      = seq;
    w.target   = target;
    w.col_inc  = col_inc;
    w.dig_calc = dig_calc;
    w.dig_adv  = dig_adv;
    return w;
  endfunction

  function automatic uword_t rom_word(pc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:  w = mk(1'b1, 1'b0, SRC_CONST, CMD_FUNC_SET, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd1:  w = mk(1'b1, 1'b0, SRC_CONST, CMD_DISP_ON, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd2:  w = mk(1'b1, 1'b0, SRC_CONST, CMD_ENTRY, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd3:  w = mk(1'b1, 1'b0, SRC_CONST, CMD_CLEAR, LAST_YES, SEQ_END, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd4:  w = mk(1'b1, 1'b0, SRC_ADDR_COL, 8'h00, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd5:  w = mk(1'b1, 1'b1, SRC_VALUE, 8'h00, LAST_YES, SEQ_END, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd6:  w = mk(1'b1, 1'b0, SRC_ADDR_COL, 8'h00, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd7:  w = mk(1'b1, 1'b1, SRC_CONST, CH_ZERO, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b1, 1'b0, 1'b0);
      4'd8:  w = mk(1'b1, 1'b0, SRC_ADDR_COL, 8'h00, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd9:  w = mk(1'b1, 1'b1, SRC_CONST, CH_X, LAST_IF_ZERO, SEQ_BRZ, PC_DIGIT,
                    1'b1, 1'b0, 1'b0);
      4'd10: w = mk(1'b1, 1'b0, SRC_ADDR_COL, 8'h00, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b0, 1'b0, 1'b0);
      4'd11: w = mk(1'b1, 1'b1, SRC_SIGN, 8'h00, LAST_IF_ZERO, SEQ_BRZ, PC_DIGIT,
                    1'b1, 1'b0, 1'b0);
      4'd12: w = mk(1'b0, 1'b0, SRC_CONST, 8'h00, LAST_NO, SEQ_BRZ, PC_DIGIT,
                    1'b0, 1'b0, 1'b0);
      4'd13: w = mk(1'b1, 1'b0, SRC_ADDR_DIG, 8'h00, LAST_NO, SEQ_NEXT, PC_INIT,
                    1'b0, 1'b1, 1'b0);
      4'd14: w = mk(1'b1, 1'b1, SRC_DIGIT, 8'h00, LAST_IF_ONE, SEQ_LOOP, PC_DIGIT,
                    1'b0, 1'b0, 1'b1);
      default: w = mk(1'b0, 1'b0, SRC_CONST, 8'h00, LAST_NO, SEQ_END, PC_INIT,
                      1'b0, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/char_lcd_number_writer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_number_writer_unit - character LCD number writer
// Turns one display request into the LCD bus writes it causes, driven by a
// microcoded sequencer over a small digit datapath.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_*     slave      tuser opcode; tdata line, column, value, digit_count
//  out_*    master     tuser is_data; tdata bus_byte; tlast last
//
//  At most one bus write per cycle from the microcode table while the output
//  is not stalled; digit counts above MAX_DIGITS are clipped, and unused
//  opcodes are accepted without causing any transaction.
//  Reset is synchronous and only clears control state.
//  A stalled output holds the sequencer; a new request is taken once the
//  final write of the previous one sits in the output register.
// ----------------------------------------------------------------------------
module char_lcd_number_writer_unit #(
  parameter int MAX_DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // opcode
  input  logic [31:0] in_tdata,   // line, column[7:0], value[15:0], digit_count[4:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [0:0]  out_tuser,  // is_data
  output logic [7:0]  out_tdata,  // bus_byte[7:0]
  output logic        out_tlast
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic                  busy_r, busy_nxt;
  clnw_pkg::pc_t         pc_r, pc_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [7:0]            col_r, col_nxt;
  logic                  line_r, line_nxt;
  logic                  neg_r, neg_nxt;
  clnw_pkg::radix_t      radix_r, radix_nxt;
  logic [15:0]           v_r, v_nxt;
  logic [15:0]           q_r, q_nxt;
  logic [3:0]            dgt_r, dgt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_is_data_r, out_is_data_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic                  out_last_r, out_last_nxt;

  clnw_pkg::uword_t      ctl;
  logic                  in_acc;
  logic                  adv;
  logic                  last_now;
  logic [7:0]            base;
  logic [7:0]            byte_now;
  logic [31:0]           prod;
  logic [12:0]           q_dec;
  logic [15:0]           q_dec10;
  logic [15:0]           r_dec;
  logic [2:0]            in_op;
  logic [4:0]            in_dc;
  logic [15:0]           in_val;

  assign ctl       = clnw_pkg::rom_word(pc_r);
  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign adv       = busy_r && (!ctl.emit || !out_valid_r || out_tready);

  assign in_op  = in_tuser;
  assign in_dc  = in_tdata[29:25];
  assign in_val = in_tdata[24:9];

  assign base    = line_r ? clnw_pkg::BASE_LINE1 : clnw_pkg::BASE_LINE0;
  assign prod    = v_r * clnw_pkg::DIV10_MUL;
  assign q_dec   = prod[31:clnw_pkg::DIV10_SHIFT];
  assign q_dec10 = {q_dec, 3'b000} + {2'b00, q_dec, 1'b0};
  assign r_dec   = v_r - q_dec10;

  always_comb begin
    case (ctl.src)
      clnw_pkg::SRC_CONST:    byte_now = ctl.cbyte;
      clnw_pkg::SRC_ADDR_COL: byte_now = base + col_r;
      clnw_pkg::SRC_ADDR_DIG: byte_now = base + col_r + 8'(cnt_r) - 8'd1;
      clnw_pkg::SRC_VALUE:    byte_now = v_r[7:0];
      clnw_pkg::SRC_SIGN:     byte_now = neg_r ? clnw_pkg::CH_MINUS : clnw_pkg::CH_PLUS;
      clnw_pkg::SRC_DIGIT:    byte_now = (dgt_r < 4'd10) ? clnw_pkg::CH_ZERO + {4'd0, dgt_r}
                                                         : clnw_pkg::CH_ALPHA_OFS + {4'd0, dgt_r};
      default:                byte_now = ctl.cbyte;
    endcase
    case (ctl.last)
      clnw_pkg::LAST_NO:      last_now = 1'b0;
      clnw_pkg::LAST_YES:     last_now = 1'b1;
      clnw_pkg::LAST_IF_ZERO: last_now = (cnt_r == '0);
      clnw_pkg::LAST_IF_ONE:  last_now = (cnt_r == CW'(1));
      default:                last_now = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt        = busy_r;
    pc_nxt          = pc_r;
    cnt_nxt         = cnt_r;
    col_nxt         = col_r;
    line_nxt        = line_r;
    neg_nxt         = neg_r;
    radix_nxt       = radix_r;
    v_nxt           = v_r;
    q_nxt           = q_r;
    dgt_nxt         = dgt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_is_data_nxt = out_is_data_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;

    if (in_acc) begin
      line_nxt  = in_tdata[0];
      col_nxt   = in_tdata[8:1];
      cnt_nxt   = ({27'd0, in_dc} > MAX_DIGITS) ? CW'(MAX_DIGITS) : CW'(in_dc);
      neg_nxt   = in_val[15];
      v_nxt     = in_val;
      radix_nxt = clnw_pkg::RAD_DEC;
      busy_nxt  = 1'b1;
      unique case (in_op)
        clnw_pkg::OP_INIT: pc_nxt = clnw_pkg::PC_INIT;
        clnw_pkg::OP_CHAR: pc_nxt = clnw_pkg::PC_CHAR;
        clnw_pkg::OP_UDEC: pc_nxt = clnw_pkg::PC_NUM;
        clnw_pkg::OP_SDEC: begin
          pc_nxt = clnw_pkg::PC_SIGNED;
          if (in_val[15]) begin
            v_nxt = ~in_val + 16'd1;
          end
        end
        clnw_pkg::OP_HEX: begin
          pc_nxt    = clnw_pkg::PC_HEX;
          radix_nxt = clnw_pkg::RAD_HEX;
        end
        clnw_pkg::OP_BIN: begin
          pc_nxt    = clnw_pkg::PC_NUM;
          radix_nxt = clnw_pkg::RAD_BIN;
        end
        default: busy_nxt = 1'b0;
      endcase
    end

    if (adv) begin
      if (ctl.emit) begin
        out_valid_nxt   = 1'b1;
        out_is_data_nxt = ctl.is_data;
        out_byte_nxt    = byte_now;
        out_last_nxt    = last_now;
      end
      if (ctl.col_inc) begin
        col_nxt = col_r + 8'd1;
      end
      if (ctl.dig_calc) begin
        case (radix_r)
          clnw_pkg::RAD_HEX: begin
            q_nxt   = {4'd0, v_r[15:4]};
            dgt_nxt = v_r[3:0];
          end
          clnw_pkg::RAD_BIN: begin
            q_nxt   = {1'b0, v_r[15:1]};
            dgt_nxt = {3'd0, v_r[0]};
          end
          default: begin
            q_nxt   = {3'd0, q_dec};
            dgt_nxt = r_dec[3:0];
          end
        endcase
      end
      if (ctl.dig_adv) begin
        v_nxt   = q_r;
        cnt_nxt = cnt_r - CW'(1);
      end
      case (ctl.seq)
        clnw_pkg::SEQ_NEXT: pc_nxt = pc_r + 4'd1;
        clnw_pkg::SEQ_END:  busy_nxt = 1'b0;
        clnw_pkg::SEQ_BRZ: begin
          if (cnt_r == '0) begin
            busy_nxt = 1'b0;
          end else begin
            pc_nxt = ctl.target;
          end
        end
        clnw_pkg::SEQ_LOOP: begin
          if (cnt_r == CW'(1)) begin
            busy_nxt = 1'b0;
          end else begin
            pc_nxt = ctl.target;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_r          <= pc_nxt;
    cnt_r         <= cnt_nxt;
    col_r         <= col_nxt;
    line_r        <= line_nxt;
    neg_r         <= neg_nxt;
    radix_r       <= radix_nxt;
    v_r           <= v_nxt;
    q_r           <= q_nxt;
    dgt_r         <= dgt_nxt;
    out_is_data_r <= out_is_data_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_is_data_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ctl.emit && last_now) |=> !busy_r)
    else $error("sequencer still busy after final write");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ctl.dig_adv) |-> (cnt_r != '0))
    else $error("digit step with no digits left");

  a_dec_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ctl.src == clnw_pkg::SRC_DIGIT && radix_r == clnw_pkg::RAD_DEC)
      |-> (dgt_r < 4'd10))
    else $error("decimal digit out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && adv && ctl.emit && !last_now) |=> busy_r)
    else $error("sequencer ended before final write");

endmodule

>>> tb/tb_char_lcd_number_writer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_number_writer_unit - character LCD number writer testbench
// Streams display requests into the block, predicts the LCD bus writes each
// accepted request causes and checks every output transaction in order,
// under random idling on both sides plus a long receiver hold-off and a
// sender pause until all pending writes have drained.
// ----------------------------------------------------------------------------
module tb_char_lcd_number_writer_unit;

  localparam int          CLK_HALF     = 2;
  localparam int          MAX_DIG      = 16;
  localparam int          N_RANDOM     = 280;
  localparam int          CYCLE_LIMIT  = 3000000;
  localparam int          TAIL_CYCLES  = 60;
  localparam int          LONG_HOLD_AT = 600;
  localparam int          LONG_HOLD    = 500;
  localparam logic [2:0]  OP_UNUSED_6  = 3'd6;
  localparam logic [2:0]  OP_UNUSED_7  = 3'd7;
  localparam logic        ROW_TOP      = 1'b0;
  localparam logic        ROW_BOTTOM   = 1'b1;

  typedef struct {
    logic [2:0]  opcode;
    logic        line;
    logic [7:0]  column;
    logic [15:0] value;
    logic [4:0]  digit_count;
    bit          drain;
  } lcd_req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;   // opcode
  logic [31:0] in_tdata = '0;   // line, column[7:0], value[15:0], digit_count[4:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [0:0]  out_tuser;       // is_data
  logic [7:0]  out_tdata;       // bus_byte[7:0]
  logic        out_tlast;

  lcd_req_t   pending_reqs_q[$];
  lcd_write_t staged_writes_q[$];
  lcd_write_t exp_writes_q[$];
  lcd_req_t   cur_req;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int got_cnt = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;
  bit long_hold_done = 1'b0;
  bit tx_busy;
  lcd_write_t got_w;
  lcd_write_t exp_w;

  char_lcd_number_writer_unit #(.MAX_DIGITS(MAX_DIG)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_char(logic line, logic [7:0] col, logic [7:0] ch);
    lcd_write_t w;
    w.is_data  = 1'b0;
    w.bus_byte = (line ? clnw_pkg::BASE_LINE1 : clnw_pkg::BASE_LINE0) + col;
    w.last     = 1'b0;
    staged_writes_q.push_back(w);
    w.is_data  = 1'b1;
    w.bus_byte = ch;
    staged_writes_q.push_back(w);
  endfunction

  function automatic void put_digits(logic line, logic [7:0] col, int unsigned v,
                                     int unsigned radix, int unsigned n);
    int unsigned d;
    logic [7:0]  c;
    for (int unsigned i = 0; i < n; i++) begin
      d = v % radix;
      v = v / radix;
      c = 8'(col + n - 1 - i);
      put_char(line, c, (d < 10) ? 8'(clnw_pkg::CH_ZERO + d)
                                 : 8'(clnw_pkg::CH_ALPHA_OFS + d));
    end
  endfunction

  function automatic void predict_lcd_writes(lcd_req_t r);
    int unsigned n;
    int unsigned mag;
    lcd_write_t  w;
    n = (r.digit_count > MAX_DIG) ? MAX_DIG : r.digit_count;
    staged_writes_q.delete();
    case (r.opcode)
      clnw_pkg::OP_INIT: begin
        w.is_data = 1'b0;
        w.last    = 1'b0;
        w.bus_byte = clnw_pkg::CMD_FUNC_SET;
        staged_writes_q.push_back(w);
        w.bus_byte = clnw_pkg::CMD_DISP_ON;
        staged_writes_q.push_back(w);
        w.bus_byte = clnw_pkg::CMD_ENTRY;
        staged_writes_q.push_back(w);
        w.bus_byte = clnw_pkg::CMD_CLEAR;
        staged_writes_q.push_back(w);
      end
      clnw_pkg::OP_CHAR: put_char(r.line, r.column, r.value[7:0]);
      clnw_pkg::OP_UDEC: put_digits(r.line, r.column, r.value, 10, n);
      clnw_pkg::OP_SDEC: begin
        if (r.value[15]) begin
          put_char(r.line, r.column, clnw_pkg::CH_MINUS);
          mag = 32'h10000 - r.value;
        end else begin
          put_char(r.line, r.column, clnw_pkg::CH_PLUS);
          mag = r.value;
        end
        put_digits(r.line, 8'(r.column + 1), mag, 10, n);
      end
      clnw_pkg::OP_HEX: begin
        put_char(r.line, r.column, clnw_pkg::CH_ZERO);
        put_char(r.line, 8'(r.column + 1), clnw_pkg::CH_X);
        put_digits(r.line, 8'(r.column + 2), r.value, 16, n);
      end
      clnw_pkg::OP_BIN: put_digits(r.line, r.column, r.value, 2, n);
      default: ;
    endcase
    if (staged_writes_q.size() > 0) begin
      staged_writes_q[staged_writes_q.size() - 1].last = 1'b1;
    end
    foreach (staged_writes_q[i]) exp_writes_q.push_back(staged_writes_q[i]);
  endfunction

  task automatic add_req(logic [2:0] op, logic line, logic [7:0] col, logic [15:0] val,
                         logic [4:0] n, bit drain);
    lcd_req_t r;
    r.opcode      = op;
    r.line        = line;
    r.column      = col;
    r.value       = val;
    r.digit_count = n;
    r.drain       = drain;
    pending_reqs_q.push_back(r);
  endtask

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    if (r < 25) return 16'h8000;
    if (r < 30) return 16'h7FFF;
    if (r < 45) return 16'($urandom_range(0, 255));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 5'($urandom_range(1, 6));
    if (r < 80) return 5'(MAX_DIG);
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [2:0] pick_opcode();
    if ($urandom_range(0, 99) < 8) return $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
    case ($urandom_range(0, 5))
      0: return clnw_pkg::OP_INIT;
      1: return clnw_pkg::OP_CHAR;
      2: return clnw_pkg::OP_UDEC;
      3: return clnw_pkg::OP_SDEC;
      4: return clnw_pkg::OP_HEX;
      default: return clnw_pkg::OP_BIN;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      tx_busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_lcd_writes(cur_req);
        tx_busy = 1'b0;
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else if ($urandom_range(0, 99) < 5) begin
          tx_calm = $urandom_range(10, 40);
          tx_gap = 0;
        end else begin
          tx_gap = pick_gap();
        end
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs_q.size() > 0 &&
                     (!pending_reqs_q[0].drain || exp_writes_q.size() == 0)) begin
          cur_req = pending_reqs_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_req.opcode;
          in_tdata  <= {2'b00, cur_req.digit_count, cur_req.value, cur_req.column,
                        cur_req.line};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_cnt++;
        got_w = '{is_data: out_tuser[0], bus_byte: out_tdata, last: out_tlast};
        if (exp_writes_q.size() == 0) begin
          $error("unexpected transaction: is_data %0d bus_byte 0x%02h last %0d",
                 got_w.is_data, got_w.bus_byte, got_w.last);
          err_cnt++;
        end else begin
          exp_w = exp_writes_q.pop_front();
          if (got_w.is_data !== exp_w.is_data) begin
            $error("is_data: expected %0d, actual %0d", exp_w.is_data, got_w.is_data);
            err_cnt++;
          end
          if (got_w.bus_byte !== exp_w.bus_byte) begin
            $error("bus_byte: expected 0x%02h, actual 0x%02h", exp_w.bus_byte,
                   got_w.bus_byte);
            err_cnt++;
          end
          if (got_w.last !== exp_w.last) begin
            $error("last: expected %0d, actual %0d", exp_w.last, got_w.last);
            err_cnt++;
          end
        end
      end
      if (got_cnt >= LONG_HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else if ($urandom_range(0, 99) < 3) begin
          rx_calm = $urandom_range(30, 120);
        end else begin
          rx_hold = pick_gap();
        end
      end
    end
  end

  initial begin
    add_req(clnw_pkg::OP_INIT, ROW_TOP, 8'd0, 16'h0000, 5'd0, 1'b0);
    add_req(clnw_pkg::OP_CHAR, ROW_TOP, 8'd0, 16'h0041, 5'd1, 1'b0);
    add_req(clnw_pkg::OP_CHAR, ROW_BOTTOM, 8'd255, 16'hFFFF, 5'd31, 1'b0);
    add_req(clnw_pkg::OP_UDEC, ROW_TOP, 8'd0, 16'hFFFF, 5'd5, 1'b0);
    add_req(clnw_pkg::OP_UDEC, ROW_BOTTOM, 8'd3, 16'h0000, 5'd16, 1'b0);
    add_req(clnw_pkg::OP_UDEC, ROW_TOP, 8'd7, 16'h1234, 5'd0, 1'b0);
    add_req(clnw_pkg::OP_UDEC, ROW_BOTTOM, 8'd200, 16'hFFFF, 5'd31, 1'b0);
    add_req(clnw_pkg::OP_UDEC, ROW_TOP, 8'd10, 16'd12345, 5'd3, 1'b0);
    add_req(clnw_pkg::OP_SDEC, ROW_TOP, 8'd1, 16'h8000, 5'd5, 1'b0);
    add_req(clnw_pkg::OP_SDEC, ROW_BOTTOM, 8'd2, 16'h7FFF, 5'd5, 1'b0);
    add_req(clnw_pkg::OP_SDEC, ROW_TOP, 8'd254, 16'hFFFF, 5'd1, 1'b0);
    add_req(clnw_pkg::OP_SDEC, ROW_BOTTOM, 8'd255, 16'h0000, 5'd0, 1'b0);
    add_req(clnw_pkg::OP_HEX, ROW_TOP, 8'd4, 16'hABCD, 5'd4, 1'b0);
    add_req(clnw_pkg::OP_HEX, ROW_BOTTOM, 8'd255, 16'hFFFF, 5'd0, 1'b0);
    add_req(clnw_pkg::OP_HEX, ROW_BOTTOM, 8'd254, 16'h1234, 5'd16, 1'b0);
    add_req(clnw_pkg::OP_BIN, ROW_TOP, 8'd0, 16'hAAAA, 5'd16, 1'b0);
    add_req(clnw_pkg::OP_BIN, ROW_TOP, 8'd5, 16'h5555, 5'd0, 1'b0);
    add_req(OP_UNUSED_6, ROW_BOTTOM, 8'd255, 16'hFFFF, 5'd31, 1'b0);
    add_req(OP_UNUSED_7, ROW_TOP, 8'd0, 16'h0000, 5'd1, 1'b0);
    add_req(clnw_pkg::OP_BIN, ROW_BOTTOM, 8'd250, 16'h5555, 5'd20, 1'b0);
    add_req(clnw_pkg::OP_INIT, ROW_BOTTOM, 8'd255, 16'hFFFF, 5'd31, 1'b1);
    add_req(clnw_pkg::OP_CHAR, ROW_BOTTOM, 8'd128, 16'h00FE, 5'd2, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      add_req(pick_opcode(), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              pick_value(), pick_count(), (i % 40) == 39);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs_q.size() > 0 || in_tvalid || exp_writes_q.size() > 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (exp_writes_q.size() > 0) begin
      $error("%0d expected transactions never arrived", exp_writes_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/clnw_pkg.sv
hw/rtl/char_lcd_number_writer_unit.sv
tb/tb_char_lcd_number_writer_unit.sv
